/* hw/rtl/gbn_pkg.sv */
// ----------------------------------------------------------------------------
// gbn_pkg
// shared types, constants and codes of the go-back-n sender
// ----------------------------------------------------------------------------
package gbn_pkg;

   // sizing
   localparam int MAX_WINDOW    = 16;
   localparam int BUFFER_DEPTH  = 64;
   localparam int PAYLOAD_BYTES = 20;
   localparam int QUEUE_DEPTH   = 2;

   localparam int BUF_AW   = $clog2(BUFFER_DEPTH);
   localparam int WIN_W    = 5;
   localparam int EWIN_W   = $clog2(MAX_WINDOW + 1);
   localparam int PL_W     = PAYLOAD_BYTES * 8;
   localparam int BSUM_W   = $clog2(PAYLOAD_BYTES * 128) + 1;
   localparam int SLOT_W   = PL_W + BSUM_W;
   localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

   // byte sum is formed in groups, then the groups are added
   localparam int GROUP_BYTES = 5;
   localparam int N_GROUPS    = PAYLOAD_BYTES / GROUP_BYTES;
   localparam int PSUM_W      = $clog2(GROUP_BYTES * 128) + 1;

   typedef enum logic [1:0] {
      CMD_MESSAGE = 2'd0,
      CMD_ACK     = 2'd1,
      CMD_TIMEOUT = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      TMR_NONE    = 2'd0,
      TMR_START   = 2'd1,
      TMR_STOP    = 2'd2,
      TMR_RESTART = 2'd3
   } timer_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DECODE,
      BK_SEND,
      BK_EMIT
   } bk_state_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [63:0]        payload_lo;
      logic [63:0]        payload_mid;
      logic [31:0]        payload_hi;
      logic [31:0]        ack_seqnum;
      logic [31:0]        ack_number;
      logic signed [31:0] ack_checksum;
   } req_type;

   typedef struct packed {
      logic               packet_valid;
      logic [31:0]        packet_seq;
      logic signed [31:0] packet_sum;
      logic [63:0]        out_payload_lo;
      logic [63:0]        out_payload_mid;
      logic [31:0]        out_payload_hi;
      logic [1:0]         timer_action;
      logic               message_dropped;
      logic               last_of_run;
   } rsp_type;

   // classified item between front and back
   typedef struct packed {
      cmd_type                   command;
      logic [PL_W-1:0]           payload;
      logic signed [BSUM_W-1:0]  byte_sum;
      logic [31:0]               ack_seqnum;
      logic [31:0]               ack_number;
      logic [31:0]               ack_checksum;
   } qent_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

/* hw/rtl/gbn_ram.sv */
// ----------------------------------------------------------------------------
// gbn_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module gbn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/gbn_front.sv */
// ----------------------------------------------------------------------------
// gbn_front
// takes items in, forms the signed payload byte sum, pushes to the queue
// ----------------------------------------------------------------------------
module gbn_front
   import gbn_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_type      req_item,
   input  q_status_type q_status,
   output logic         q_push,
   output qent_type     q_data
);

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_item_ff;
   logic    s2_valid_ff, s2_valid_in;
   req_type s2_item_ff;
   logic signed [PSUM_W-1:0] s2_psum_ff [N_GROUPS];
   logic signed [PSUM_W-1:0] psum_in [N_GROUPS];

   logic s2_free, s1_free, accept;
   logic [PL_W-1:0] s1_payload;
   logic signed [BSUM_W-1:0] bsum;

   assign s2_free = !s2_valid_ff || !q_status.full;
   assign s1_free = !s1_valid_ff || s2_free;
   assign busy    = !s1_free;
   assign accept  = start && !busy;
   assign q_push  = s2_valid_ff && !q_status.full;

   assign s1_valid_in = accept || (s1_valid_ff && !s2_free);
   assign s2_valid_in = s2_free ? s1_valid_ff : s2_valid_ff;

   assign s1_payload = {s1_item_ff.payload_hi, s1_item_ff.payload_mid, s1_item_ff.payload_lo};

   // one partial sum of signed bytes per group
   always_comb begin
      logic signed [PSUM_W-1:0] acc;
      logic [7:0] bt;
      for (int g = 0; g < N_GROUPS; g++) begin
         acc = '0;
         for (int b = 0; b < GROUP_BYTES; b++) begin
            bt  = s1_payload[8*(g*GROUP_BYTES+b) +: 8];
            acc = acc + {{(PSUM_W-8){bt[7]}}, bt};
         end
         psum_in[g] = acc;
      end
   end

   always_comb begin
      logic signed [BSUM_W-1:0] acc;
      acc = '0;
      for (int g = 0; g < N_GROUPS; g++) begin
         acc = acc + {{(BSUM_W-PSUM_W){s2_psum_ff[g][PSUM_W-1]}}, s2_psum_ff[g]};
      end
      bsum = acc;
   end

   always_comb begin
      q_data.command      = cmd_type'(s2_item_ff.command);
      q_data.payload      = {s2_item_ff.payload_hi, s2_item_ff.payload_mid,
                             s2_item_ff.payload_lo};
      q_data.byte_sum     = bsum;
      q_data.ack_seqnum   = s2_item_ff.ack_seqnum;
      q_data.ack_number   = s2_item_ff.ack_number;
      q_data.ack_checksum = s2_item_ff.ack_checksum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (accept) begin
         s1_item_ff <= req_item;
      end
      if (s2_free) begin
         s2_item_ff <= s1_item_ff;
         s2_psum_ff <= psum_in;
      end
   end

endmodule

/* hw/rtl/gbn_queue.sv */
// ----------------------------------------------------------------------------
// gbn_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
module gbn_queue
   import gbn_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  qent_type     push_data,
   input  logic         pop,
   output qent_type     pop_data,
   output q_status_type status
);

   qent_type entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      ptr_next = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
   assign rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/gbn_back.sv */
// ----------------------------------------------------------------------------
// gbn_back
// window state, message buffer and packet sequencer
// ----------------------------------------------------------------------------
module gbn_back
   import gbn_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [WIN_W-1:0] window_size,
   input  q_status_type     q_status,
   input  qent_type         q_data,
   output logic             q_pop,
   output logic             rsp_strobe,
   output rsp_type          rsp_item
);

   bk_state_type state_ff, state_in;
   qent_type     cur_ff, cur_in;
   logic [31:0]  base_ff, base_in;
   logic [31:0]  next_ff, next_in;
   logic [31:0]  queued_ff, queued_in;
   logic         drop_ff, drop_in;
   logic [31:0]  seq_ff, seq_in;
   logic         tstart_ff, tstart_in;
   rsp_type      rsp_ff, rsp_in;
   logic         strobe_ff, strobe_in;

   logic              ram_we;
   logic [SLOT_W-1:0] ram_rdata;
   logic [PL_W-1:0]   rd_payload;
   logic signed [BSUM_W-1:0] rd_bsum;

   logic [EWIN_W-1:0] eff_win;
   logic              can_send, buf_full, ack_ok, ack_in_win;
   logic [31:0]       ack_sum, ack_next;

   // window size of zero acts as one, above the maximum as the maximum
   always_comb begin
      if (window_size == '0) begin
         eff_win = EWIN_W'(1);
      end else if (32'(window_size) > 32'(MAX_WINDOW)) begin
         eff_win = EWIN_W'(MAX_WINDOW);
      end else begin
         eff_win = EWIN_W'(window_size);
      end
   end

   assign can_send = (next_ff != queued_ff) && ((next_ff - base_ff) < 32'(eff_win));
   assign buf_full = (queued_ff - base_ff) >= 32'(BUFFER_DEPTH);

   assign ack_sum    = cur_ff.ack_seqnum + cur_ff.ack_number
                       + {{(32-BSUM_W){cur_ff.byte_sum[BSUM_W-1]}}, cur_ff.byte_sum};
   assign ack_in_win = (cur_ff.ack_number - base_ff) < (next_ff - base_ff);
   assign ack_ok     = (ack_sum == cur_ff.ack_checksum) && ack_in_win;
   assign ack_next   = cur_ff.ack_number + 32'd1;

   assign rd_payload = ram_rdata[SLOT_W-1 -: PL_W];
   assign rd_bsum    = ram_rdata[BSUM_W-1:0];

   assign ram_we = (state_ff == BK_DECODE) && (cur_ff.command == CMD_MESSAGE) && !buf_full;

   gbn_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (queued_ff[BUF_AW-1:0]),
      .wr_data ({cur_ff.payload, cur_ff.byte_sum}),
      .rd_addr (next_ff[BUF_AW-1:0]),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      base_in   = base_ff;
      next_in   = next_ff;
      queued_in = queued_ff;
      drop_in   = drop_ff;
      seq_in    = seq_ff;
      tstart_in = tstart_ff;
      rsp_in    = '0;
      strobe_in = 1'b0;
      q_pop     = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               cur_in   = q_data;
               state_in = BK_DECODE;
            end
         end

         BK_DECODE: begin
            unique case (cur_ff.command)
               CMD_MESSAGE: begin
                  drop_in  = buf_full;
                  state_in = BK_SEND;
                  if (!buf_full) begin
                     queued_in = queued_ff + 32'd1;
                  end
               end
               CMD_ACK: begin
                  strobe_in          = 1'b1;
                  rsp_in.last_of_run = 1'b1;
                  state_in           = BK_IDLE;
                  if (ack_ok) begin
                     base_in = ack_next;
                     rsp_in.timer_action = (ack_next == next_ff) ? TMR_STOP : TMR_RESTART;
                  end
               end
               CMD_TIMEOUT: begin
                  drop_in  = 1'b0;
                  next_in  = base_ff;
                  state_in = BK_SEND;
               end
               CMD_NONE: begin
                  strobe_in          = 1'b1;
                  rsp_in.last_of_run = 1'b1;
                  state_in           = BK_IDLE;
               end
               default: state_in = BK_IDLE;
            endcase
         end

         BK_SEND: begin
            if (can_send) begin
               // read is on its way; the packet is formed in emit and then registered out
               seq_in    = next_ff;
               tstart_in = (base_ff == next_ff);
               next_in   = next_ff + 32'd1;
               state_in  = BK_EMIT;
            end else begin
               strobe_in              = 1'b1;
               rsp_in.message_dropped = drop_ff;
               rsp_in.last_of_run     = 1'b1;
               state_in               = BK_IDLE;
            end
         end

         BK_EMIT: begin
            strobe_in              = 1'b1;
            rsp_in.packet_valid    = 1'b1;
            rsp_in.packet_seq      = seq_ff;
            rsp_in.packet_sum      = seq_ff + {{(32-BSUM_W){rd_bsum[BSUM_W-1]}}, rd_bsum};
            rsp_in.out_payload_lo  = rd_payload[63:0];
            rsp_in.out_payload_mid = rd_payload[127:64];
            rsp_in.out_payload_hi  = rd_payload[159:128];
            rsp_in.timer_action    = tstart_ff ? TMR_START : TMR_NONE;
            rsp_in.message_dropped = drop_ff;
            rsp_in.last_of_run     = !can_send;
            if (can_send) begin
               seq_in    = next_ff;
               tstart_in = (base_ff == next_ff);
               next_in   = next_ff + 32'd1;
            end else begin
               state_in = BK_IDLE;
            end
         end

         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         base_ff   <= '0;
         next_ff   <= '0;
         queued_ff <= '0;
         drop_ff   <= 1'b0;
         tstart_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         base_ff   <= base_in;
         next_ff   <= next_in;
         queued_ff <= queued_in;
         drop_ff   <= drop_in;
         tstart_ff <= tstart_in;
         strobe_ff <= strobe_in;
      end
      cur_ff <= cur_in;
      seq_ff <= seq_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

/* hw/rtl/go_back_n_sender_top.sv */
// ----------------------------------------------------------------------------
// go_back_n_sender_top
// go-back-n arq sender: message buffer, sliding window, packet checksums
// ----------------------------------------------------------------------------
// usage
//   - an item (new message, ack packet or timer expiry) is taken on req_item
//     at a clock edge with start high and busy low
//   - every item gives one or more results on rsp_item, each shown for one
//     cycle with rsp_strobe high; the last result of an item has last_of_run
//   - the receiver cannot stall: results are never held back
//   - csr_we writes the window size from csr_wdata; write only while idle
//   - with the sequencer idle, an ack or ignored command has its result
//     registered from decode, a message or timeout its first packet from
//     emit after send and the ram read (from send when nothing is sent)
//   - an ack or ignored command passes idle and decode in the sequencer; a
//     message or timeout passes idle, decode and send, then emit while up to
//     a window of packets leave one per cycle as the buffer ram streams them out
//   - the front takes new items while the sequencer works; once both front
//     stages and the two-entry queue hold items, busy goes high
//   - reset: window base, next sequence number and message count go to zero,
//     window size to one; buffer contents are undefined until written
// ----------------------------------------------------------------------------
module go_back_n_sender_top
   import gbn_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_item,
   output logic             rsp_strobe,
   output rsp_type          rsp_item,
   input  logic             csr_we,
   input  logic [WIN_W-1:0] csr_wdata
);

   // window size register
   logic [WIN_W-1:0] window_ff, window_in;

   // front to back queue signals
   logic         q_push, q_pop;
   qent_type     q_push_data, q_pop_data;
   q_status_type q_status;

   assign window_in = csr_we ? csr_wdata : window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WIN_W'(1);
      end else begin
         window_ff <= window_in;
      end
   end

   // front: takes items, forms the payload byte sum over two stages
   gbn_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .q_status (q_status),
      .q_push   (q_push),
      .q_data   (q_push_data)
   );

   // short queue so the front keeps taking items while packets stream out
   gbn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   // back: window state, buffer ram and packet sequencer
   gbn_back u_back (
      .clock       (clock),
      .reset       (reset),
      .window_size (window_ff),
      .q_status    (q_status),
      .q_data      (q_pop_data),
      .q_pop       (q_pop),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item)
   );

   // the front never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_status.full))
      else $error("queue push while full");

   // a result without a packet always closes its run
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.packet_valid) |-> rsp_item.last_of_run)
      else $error("result without packet not marked last");

   // packets of one run leave in consecutive cycles
   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.packet_valid && !rsp_item.last_of_run)
      |=> (rsp_strobe && rsp_item.packet_valid))
      else $error("packet run broken");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// go-back-n sender testbench: a directed table, then random command traffic
// under several window sizes, with a buffer-full flood. Every result is
// checked field by field: typed rows against their own answer, the rest
// against a bench model of the window, message ring and packet checksum.
// ----------------------------------------------------------------------------
module tb;
   import gbn_pkg::*;

   localparam int LIMIT_CYCLES  = 200000;
   // cycles the sequencer may still need after its last result
   localparam int SETTLE_CYCLES = 12;

   localparam logic [PL_W-1:0] PL_ZERO  = '0;
   localparam logic [PL_W-1:0] PL_ONES  = '1;
   localparam logic [PL_W-1:0] PL_NEG   = {PAYLOAD_BYTES{8'h80}};
   localparam logic [PL_W-1:0] PL_POS   = {PAYLOAD_BYTES{8'h7f}};

   // one line of the directed table; typed rows carry their own answer
   typedef struct packed {
      logic    typed;
      rsp_type want;
      req_type item;
   } row_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_item;
   logic             rsp_strobe;
   rsp_type          rsp_item;
   logic             csr_we;
   logic [WIN_W-1:0] csr_wdata;

   // sender state as the model sees it
   logic [31:0]      win_base;
   logic [31:0]      next_seq;
   logic [31:0]      msg_count;
   logic [WIN_W-1:0] win_reg;
   logic [PL_W-1:0]  msg_store [BUFFER_DEPTH];

   rsp_type          expected_q[$];   // results still owed by the block
   rsp_type          step_q[$];       // results of the item just accepted
   row_type          directed_rows[$];

   int               fail_count  = 0;
   int               burst_left  = 0;
   logic             steady      = 1'b0;
   int unsigned      cycle_count = 0;

   always #5 clock = ~clock;

   go_back_n_sender_top u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // model
   // ------------------------------------------------------------------------

   // wrapping sum of seq, ack and the 20 payload bytes taken as signed
   function automatic logic [31:0] frame_sum(logic [31:0] seq, logic [31:0] ack,
                                             logic [PL_W-1:0] pl);
      logic [31:0] s;
      s = seq + ack;
      for (int i = 0; i < PAYLOAD_BYTES; i++)
         s = s + {{24{pl[8*i+7]}}, pl[8*i +: 8]};
      return s;
   endfunction

   // release packets while the window has room and messages are waiting
   function automatic void send_window(logic dropped);
      logic [31:0]     limit;
      logic [PL_W-1:0] pl;
      rsp_type         res;
      int              k;
      // window size 0 behaves as 1, anything past the maximum is clipped
      if (win_reg == 0)
         limit = 1;
      else if (win_reg > MAX_WINDOW)
         limit = MAX_WINDOW;
      else
         limit = 32'(win_reg);
      k = 0;
      while (next_seq != msg_count && (next_seq - win_base) < limit && k < MAX_WINDOW) begin
         pl                  = msg_store[next_seq[BUF_AW-1:0]];
         res                 = '0;
         res.packet_valid    = 1'b1;
         res.packet_seq      = next_seq;
         res.packet_sum      = frame_sum(next_seq, 32'd0, pl);
         {res.out_payload_hi, res.out_payload_mid, res.out_payload_lo} = pl;
         // the first packet out of an empty window starts the timer
         res.timer_action    = (win_base == next_seq) ? TMR_START : TMR_NONE;
         res.message_dropped = dropped;
         step_q.insert(step_q.size(), res);
         next_seq++;
         k++;
      end
   endfunction

   // work out every result of one accepted item into step_q
   function automatic void predict_item(req_type r);
      logic [PL_W-1:0] pl;
      logic [31:0]     backlog;
      rsp_type         res;
      pl      = {r.payload_hi, r.payload_mid, r.payload_lo};
      backlog = msg_count - win_base;
      res     = '0;
      step_q.delete();
      case (r.command)
         CMD_MESSAGE: begin
            if (backlog >= BUFFER_DEPTH) begin
               // ring full: message refused, flag rides on whatever goes out
               res.message_dropped = 1'b1;
               send_window(1'b1);
            end else begin
               msg_store[msg_count[BUF_AW-1:0]] = pl;
               msg_count++;
               send_window(1'b0);
            end
         end
         CMD_ACK: begin
            // good checksum and a number inside base .. next-1
            if (frame_sum(r.ack_seqnum, r.ack_number, pl) == r.ack_checksum &&
                (r.ack_number - win_base) < (next_seq - win_base)) begin
               win_base         = r.ack_number + 1;
               res.timer_action = (win_base == next_seq) ? TMR_STOP : TMR_RESTART;
            end
         end
         CMD_TIMEOUT: begin
            // go back to the base and resend
            next_seq = win_base;
            send_window(1'b0);
         end
         default: ;  // unused command code, plain acknowledgement result
      endcase
      if (step_q.size() == 0)
         step_q.insert(step_q.size(), res);
      res = step_q.pop_back();
      res.last_of_run = 1'b1;
      step_q.insert(step_q.size(), res);
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   function automatic req_type cmd_item(cmd_type cmd, logic [PL_W-1:0] pl,
                                        logic [31:0] aseq, logic [31:0] anum,
                                        logic [31:0] asum);
      req_type r;
      r              = '0;
      r.command      = cmd;
      {r.payload_hi, r.payload_mid, r.payload_lo} = pl;
      r.ack_seqnum   = aseq;
      r.ack_number   = anum;
      r.ack_checksum = asum;
      return r;
   endfunction

   function automatic req_type random_req(cmd_type cmd);
      return cmd_item(cmd, {$urandom, $urandom, $urandom, $urandom, $urandom},
                      $urandom, $urandom, $urandom);
   endfunction

   // single closing result with no packet
   function automatic rsp_type closing(logic [1:0] timer);
      rsp_type res;
      res              = '0;
      res.timer_action = timer;
      res.last_of_run  = 1'b1;
      return res;
   endfunction

   function automatic void add_row(logic typed, rsp_type want, req_type item);
      row_type row;
      row.typed = typed;
      row.want  = want;
      row.item  = item;
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   // present one item, hold it until taken, then log what it must produce
   task automatic send_item(req_type r, logic typed, rsp_type want);
      int gap;
      start    <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_item(r);
      if (typed)
         expected_q.insert(expected_q.size(), want);
      else
         while (step_q.size() != 0) expected_q.insert(expected_q.size(), step_q.pop_front());
      // sender works in bursts; a random gap, possibly none, follows each burst unless steady
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap        = steady ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // wait until every owed result is in and the sequencer has wound down
   task automatic settle();
      start <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(logic [WIN_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      win_reg    = value;
   endtask

   // mostly well-formed traffic: messages, in-window acks, timeouts
   task automatic random_item();
      req_type         r;
      logic [PL_W-1:0] pl;
      logic [31:0]     flight;
      int              pick;
      pick = $urandom_range(0, 99);
      if (pick < 45)
         r = random_req(CMD_MESSAGE);
      else if (pick < 77)
         r = random_req(CMD_ACK);
      else if (pick < 95)
         r = random_req(CMD_TIMEOUT);
      else
         r = random_req(CMD_NONE);
      // now and then a payload at the byte extremes
      case ($urandom_range(0, 9))
         0:       pl = PL_ONES;
         1:       pl = PL_NEG;
         2:       pl = PL_POS;
         3:       pl = PL_ZERO;
         default: pl = {r.payload_hi, r.payload_mid, r.payload_lo};
      endcase
      {r.payload_hi, r.payload_mid, r.payload_lo} = pl;
      if (r.command == CMD_ACK) begin
         flight = next_seq - win_base;
         if (flight != 0 && $urandom_range(0, 9) < 7)
            r.ack_number = win_base + $urandom_range(0, flight - 1);
         else
            case ($urandom_range(0, 3))
               0:       r.ack_number = next_seq;      // one past the window
               1:       r.ack_number = win_base - 1;  // already acknowledged
               default: ;                             // anywhere
            endcase
         // mostly a good checksum, sometimes one bit off, rarely garbage
         case ($urandom_range(0, 9))
            0:       ;
            1:       r.ack_checksum = frame_sum(r.ack_seqnum, r.ack_number, pl) ^
                                      (32'd1 << $urandom_range(0, 31));
            default: r.ack_checksum = frame_sum(r.ack_seqnum, r.ack_number, pl);
         endcase
      end
      send_item(r, 1'b0, '0);
   endtask

   // fill the ring with a one-packet window until messages are refused
   task automatic flood_buffer();
      req_type r;
      int      fill;
      write_window(5'd1);
      fill = BUFFER_DEPTH - (msg_count - win_base) + 3;
      repeat (fill) send_item(random_req(CMD_MESSAGE), 1'b0, '0);
      // ring still full, window opened past the maximum: a refused message
      // releases flagged packets until the clipped window is full
      settle();
      write_window(5'd31);
      send_item(random_req(CMD_MESSAGE), 1'b0, '0);
      // cumulative ack of everything in flight frees those slots of the ring
      r            = random_req(CMD_ACK);
      r.ack_number = next_seq - 1;
      r.ack_checksum = frame_sum(r.ack_seqnum, r.ack_number,
                                 {r.payload_hi, r.payload_mid, r.payload_lo});
      send_item(r, 1'b0, '0);
   endtask

   // ------------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------------

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // results cannot be held off, so every strobe is taken as it comes
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_item);
            fail_count++;
         end else begin
            want = expected_q.pop_front();
            check_field("packet_valid",    64'(want.packet_valid),
                        64'(rsp_item.packet_valid));
            check_field("packet_seq",      64'(want.packet_seq),
                        64'(rsp_item.packet_seq));
            check_field("packet_sum",      64'(want.packet_sum),
                        64'(rsp_item.packet_sum));
            check_field("out_payload_lo",  want.out_payload_lo,  rsp_item.out_payload_lo);
            check_field("out_payload_mid", want.out_payload_mid, rsp_item.out_payload_mid);
            check_field("out_payload_hi",  64'(want.out_payload_hi),
                        64'(rsp_item.out_payload_hi));
            check_field("timer_action",    64'(want.timer_action),
                        64'(rsp_item.timer_action));
            check_field("message_dropped", 64'(want.message_dropped),
                        64'(rsp_item.message_dropped));
            check_field("last_of_run",     64'(want.last_of_run),
                        64'(rsp_item.last_of_run));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("[go_back_n_sender_top] ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      rsp_type first_pkt;

      reset     <= 1'b1;
      start     <= 1'b0;
      req_item  <= '0;
      csr_we    <= 1'b0;
      csr_wdata <= '0;
      repeat (7) @(posedge clock);
      reset     <= 1'b0;
      win_base   = 0;
      next_seq   = 0;
      msg_count  = 0;
      win_reg    = WIN_W'(1);
      @(posedge clock);

      // first message after reset goes out at once with a one-packet window
      first_pkt              = closing(TMR_START);
      first_pkt.packet_valid = 1'b1;

      // directed table, run at the reset window of one
      // unused command code with every field set
      add_row(1, closing(TMR_NONE), cmd_item(CMD_NONE, PL_ONES, '1, '1, '1));
      // ack and timeout with nothing in flight
      add_row(1, closing(TMR_NONE), cmd_item(CMD_ACK, PL_ZERO, 0, 0, 0));
      add_row(1, closing(TMR_NONE), cmd_item(CMD_TIMEOUT, PL_ZERO, 0, 0, 0));
      // messages at the byte extremes; only the first fits the window
      add_row(1, first_pkt,         cmd_item(CMD_MESSAGE, PL_ZERO, 0, 0, 0));
      add_row(1, closing(TMR_NONE), cmd_item(CMD_MESSAGE, PL_ONES, 0, 0, 0));
      add_row(1, closing(TMR_NONE), cmd_item(CMD_MESSAGE, PL_NEG, 0, 0, 0));
      add_row(1, closing(TMR_NONE), cmd_item(CMD_MESSAGE, PL_POS, 0, 0, 0));
      // corrupt ack, checksum at its most negative
      add_row(1, closing(TMR_NONE), cmd_item(CMD_ACK, PL_ZERO, 0, 0, 32'h8000_0000));
      // good checksum, ack number one past the window
      add_row(1, closing(TMR_NONE), cmd_item(CMD_ACK, PL_ZERO, 0, 1, 1));
      // good ack of the only packet in flight empties the window
      add_row(1, closing(TMR_STOP), cmd_item(CMD_ACK, PL_ZERO, 0, 0, 0));
      // same ack again now sits below the base
      add_row(1, closing(TMR_NONE), cmd_item(CMD_ACK, PL_ZERO, 0, 0, 0));
      // resend from the base, then acks and timeouts over the extremes
      add_row(0, '0, cmd_item(CMD_TIMEOUT, PL_ZERO, 0, 0, 0));
      add_row(0, '0, cmd_item(CMD_ACK, PL_ONES, '1, 1, frame_sum('1, 1, PL_ONES)));
      add_row(0, '0, cmd_item(CMD_TIMEOUT, PL_ZERO, 0, 0, 0));
      add_row(0, '0, cmd_item(CMD_TIMEOUT, PL_ONES, '1, '1, '1));
      add_row(0, '0, cmd_item(CMD_ACK, PL_POS, 32'd12345, 2, frame_sum(32'd12345, 2, PL_POS)));
      add_row(0, '0, cmd_item(CMD_TIMEOUT, PL_ZERO, 0, 0, 0));
      add_row(1, closing(TMR_NONE), cmd_item(CMD_NONE, PL_ZERO, 0, 0, 0));
      // far outside the window, checksum at all ones
      add_row(1, closing(TMR_NONE), cmd_item(CMD_ACK, PL_ZERO, 0, '1, '1));

      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

      // random phases, window written between them while idle
      settle();
      write_window(5'd16);
      repeat (10) random_item();

      // window zero acts as one; no gaps from the sender here
      settle();
      write_window(5'd0);
      steady = 1'b1;
      repeat (10) random_item();
      steady = 1'b0;

      settle();
      flood_buffer();

      settle();
      write_window(5'd5);
      repeat (10) random_item();

      settle();
      write_window(WIN_W'($urandom_range(1, 16)));
      repeat (10) random_item();

      settle();
      write_window(5'd2);
      repeat (10) random_item();

      settle();
      if (fail_count == 0)
         $display("[go_back_n_sender_top] OK");
      else
         $display("[go_back_n_sender_top] ERROR");
      $finish;
   end

endmodule
